FILE: src/blrc_pkg.sv
// shared widths, register indexes, item structs and helpers for the bond length range check
// no dependencies

package blrc_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int ADIFF_W     = COORD_WIDTH + 1;
  localparam int SQ_W        = 2 * ADIFF_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int ROOT_W      = SUM_W / 2;
  localparam int REM_W       = ROOT_W + 2;
  localparam int LEN_W       = 26;
  localparam int LIM_SQ_W    = 2 * LEN_W;
  localparam int CMP_W       = (SUM_W > LIM_SQ_W) ? SUM_W : LIM_SQ_W;
  localparam int EXT_W       = (ROOT_W > LEN_W) ? ROOT_W : LEN_W;
  localparam int CNT_W       = 16;
  localparam int FRAME_W     = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = LEN_W;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SITES_PER_CHAIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHAINS_PER_FRAME = 2'd3;

  localparam logic [LEN_W-1:0] MIN_LENGTH_RST       = 26'd4096;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST       = 26'd8192;
  localparam logic [CNT_W-1:0] SITES_PER_CHAIN_RST  = 16'd66;
  localparam logic [CNT_W-1:0] CHAINS_PER_FRAME_RST = 16'd100;
  localparam logic [CNT_W-1:0] MIN_SITES            = 16'd2;
  localparam logic [CNT_W-1:0] MIN_CHAINS           = 16'd1;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [CNT_W-1:0]   chain;
    logic [CNT_W-1:0]   bond;
  } tag_t;

  typedef struct packed {
    logic               valid;
    logic [ADIFF_W-1:0] dx;
    logic [ADIFF_W-1:0] dy;
    logic [ADIFF_W-1:0] dz;
    logic [LEN_W-1:0]   min_len;
    logic [LEN_W-1:0]   max_len;
    tag_t               tag;
  } dist_t;

  typedef struct packed {
    logic              valid;
    logic [SUM_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    tag_t              tag;
  } root_t;

  function automatic logic [ADIFF_W-1:0] abs_diff(input logic [COORD_WIDTH-1:0] a,
                                                  input logic [COORD_WIDTH-1:0] b);
    logic [ADIFF_W-1:0] d;
    d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
    return d[ADIFF_W-1] ? (~d + ADIFF_W'(1)) : d;
  endfunction

endpackage

FILE: src/blrc_dist.sv
// squared distance stages: squares of the coordinate differences and limits, sum and range test
// depends on blrc_pkg

module blrc_dist import blrc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  dist_t dist_i,
  output root_t root_o
);

  dist_t                s1_q;
  logic [SQ_W-1:0]      sqx_q, sqy_q, sqz_q;
  logic [SQ_W-1:0]      sqx_d, sqy_d, sqz_d;
  logic [LIM_SQ_W-1:0]  lo_q, hi_q, lo_d, hi_d;
  tag_t                 tag_b_q;
  logic                 vb_q;
  logic [CMP_W-1:0]     sum;
  logic                 out_of_range;
  root_t                root_d, root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (en_i) begin
      s1_q <= dist_i;
    end
  end

  assign sqx_d = SQ_W'(s1_q.dx) * SQ_W'(s1_q.dx);
  assign sqy_d = SQ_W'(s1_q.dy) * SQ_W'(s1_q.dy);
  assign sqz_d = SQ_W'(s1_q.dz) * SQ_W'(s1_q.dz);
  assign lo_d  = LIM_SQ_W'(s1_q.min_len) * LIM_SQ_W'(s1_q.min_len);
  assign hi_d  = LIM_SQ_W'(s1_q.max_len) * LIM_SQ_W'(s1_q.max_len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= s1_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q   <= sqx_d;
      sqy_q   <= sqy_d;
      sqz_q   <= sqz_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      tag_b_q <= s1_q.tag;
    end
  end

  assign sum          = CMP_W'(sqx_q) + CMP_W'(sqy_q) + CMP_W'(sqz_q);
  assign out_of_range = (sum > CMP_W'(hi_q)) || (sum < CMP_W'(lo_q));

  always_comb begin
    root_d.valid = vb_q && out_of_range;
    root_d.rad   = sum[SUM_W-1:0];
    root_d.rem   = '0;
    root_d.root  = '0;
    root_d.tag   = tag_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (en_i) begin
      root_q <= root_d;
    end
  end

  assign root_o = root_q;

endmodule

FILE: src/blrc_cell.sv
// one square root cell: brings down two radicand bits and settles one root bit
// depends on blrc_pkg

module blrc_cell import blrc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  root_t cell_i,
  output root_t cell_o
);

  logic [REM_W-1:0] r_ext;
  logic [REM_W-1:0] trial;
  logic             ge;
  root_t            cell_d, cell_q;

  assign r_ext = {cell_i.rem[REM_W-3:0], cell_i.rad[SUM_W-1 -: 2]};
  assign trial = {cell_i.root, 2'b01};
  assign ge    = (r_ext >= trial);

  always_comb begin
    cell_d.valid = cell_i.valid;
    cell_d.rad   = {cell_i.rad[SUM_W-3:0], 2'b00};
    cell_d.rem   = ge ? (r_ext - trial) : r_ext;
    cell_d.root  = {cell_i.root[ROOT_W-2:0], ge};
    cell_d.tag   = cell_i.tag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

FILE: src/bond_length_range_check_unit.sv
// top level of the bond length range check: config registers, site/chain/frame counters,
// distance stages, square root cell chain and output register
// depends on blrc_pkg, blrc_dist, blrc_cell
//
// usage:
// input channel carries one site (pos_x_i, pos_y_i, pos_z_i, signed Q12.12) per item,
// handshake in_valid_i / in_stall_o. output channel carries one flagged bond per item
// (frame, chain, bond index and unsigned Q14.12 length), handshake out_valid_o / out_stall_i.
// the first site of each chain yields no item; a later site yields one only when its
// bond is longer than max_length or shorter than min_length.
// registers are written through cfg_valid_i / cfg_ready_o with cfg_index_i, cfg_data_i;
// cfg_ready_o is always high.
// throughput: one site per cycle while the output item is not stalled. between the
// taking of its site and out_valid_o, a flagged bond passes three distance stages, one
// cell per root bit for 26 root bits, and the output register.
// the whole pipeline moves as one; when the output item is stalled, every stage holds and
// in_stall_o is raised until the output item is taken.
// reset: limits 1.0 and 2.0, 66 sites per chain, 100 chains per frame, counters at
// chain 1 frame 1, next site starts a chain, pipeline empty. no clearing pass.

module bond_length_range_check_unit import blrc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [FRAME_W-1:0]            frame_index_o,
  output logic [CNT_W-1:0]              chain_index_o,
  output logic [CNT_W-1:0]              bond_index_o,
  output logic [LEN_W-1:0]              bond_length_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  logic [LEN_W-1:0]       min_len_q, max_len_q;
  logic [CNT_W-1:0]       spc_q, cpf_q, spc_eff, cpf_eff;
  logic [COORD_WIDTH-1:0] prev_x_q, prev_y_q, prev_z_q;
  logic [CNT_W-1:0]       site_count_q, site_count_d;
  logic [CNT_W-1:0]       chain_count_q, chain_count_d;
  logic [FRAME_W-1:0]     frame_count_q, frame_count_d;
  logic                   adv, accept, cfg_we;
  dist_t                  dist_d;
  root_t                  stage_chain [ROOT_W+1];
  root_t                  last;
  logic [EXT_W-1:0]       root_ext;
  logic [LEN_W-1:0]       len_d;
  logic                   out_valid_q;
  tag_t                   out_tag_q;
  logic [LEN_W-1:0]       out_len_q;

  assign adv         = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !adv;
  assign accept      = in_valid_i && adv;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LENGTH_RST;
      max_len_q <= MAX_LENGTH_RST;
      spc_q     <= SITES_PER_CHAIN_RST;
      cpf_q     <= CHAINS_PER_FRAME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_MIN_LENGTH:       min_len_q <= cfg_data_i;
        REG_MAX_LENGTH:       max_len_q <= cfg_data_i;
        REG_SITES_PER_CHAIN:  spc_q     <= cfg_data_i[CNT_W-1:0];
        REG_CHAINS_PER_FRAME: cpf_q     <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign spc_eff = (spc_q < MIN_SITES) ? MIN_SITES : spc_q;
  assign cpf_eff = (cpf_q < MIN_CHAINS) ? MIN_CHAINS : cpf_q;

  // chain position bookkeeping
  always_comb begin
    site_count_d  = site_count_q;
    chain_count_d = chain_count_q;
    frame_count_d = frame_count_q;
    if (site_count_q == '0) begin
      site_count_d = CNT_W'(1);
    end else if (({1'b0, site_count_q} + (CNT_W+1)'(1)) >= {1'b0, spc_eff}) begin
      site_count_d = '0;
      if (chain_count_q >= cpf_eff) begin
        chain_count_d = CNT_W'(1);
        if (frame_count_q != {FRAME_W{1'b1}}) begin
          frame_count_d = frame_count_q + FRAME_W'(1);
        end
      end else begin
        chain_count_d = chain_count_q + CNT_W'(1);
      end
    end else begin
      site_count_d = site_count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q      <= '0;
      prev_y_q      <= '0;
      prev_z_q      <= '0;
      site_count_q  <= '0;
      chain_count_q <= CNT_W'(1);
      frame_count_q <= FRAME_W'(1);
    end else if (accept) begin
      prev_x_q      <= pos_x_i;
      prev_y_q      <= pos_y_i;
      prev_z_q      <= pos_z_i;
      site_count_q  <= site_count_d;
      chain_count_q <= chain_count_d;
      frame_count_q <= frame_count_d;
    end
  end

  always_comb begin
    dist_d.valid     = accept && (site_count_q != '0);
    dist_d.dx        = abs_diff(pos_x_i, prev_x_q);
    dist_d.dy        = abs_diff(pos_y_i, prev_y_q);
    dist_d.dz        = abs_diff(pos_z_i, prev_z_q);
    dist_d.min_len   = min_len_q;
    dist_d.max_len   = max_len_q;
    dist_d.tag.frame = frame_count_q;
    dist_d.tag.chain = chain_count_q;
    dist_d.tag.bond  = site_count_q;
  end

  blrc_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .dist_i (dist_d),
    .root_o (stage_chain[0])
  );

  for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
    blrc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .cell_i (stage_chain[g]),
      .cell_o (stage_chain[g+1])
    );
  end

  assign last     = stage_chain[ROOT_W];
  assign root_ext = EXT_W'(last.root);
  assign len_d    = (root_ext > EXT_W'(LEN_MAX)) ? LEN_MAX : root_ext[LEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_tag_q <= last.tag;
      out_len_q <= len_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_index_o = out_tag_q.frame;
  assign chain_index_o = out_tag_q.chain;
  assign bond_index_o  = out_tag_q.bond;
  assign bond_length_o = out_len_q;

  a_counts_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_count_q != '0) && (frame_count_q != '0))
    else $error("chain or frame counter reached zero");

  a_site_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    site_count_q != {CNT_W{1'b1}})
    else $error("site counter exceeded largest chain size");

  a_frame_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_count_q >= $past(frame_count_q))
    else $error("frame counter went backwards");

  a_out_indices: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bond_index_o != '0) && (chain_index_o != '0))
    else $error("result item with a zero bond or chain index");

endmodule
